@@ sv/nsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the nearest sphere distance/color block.
// ----------------------------------------------------------------------------
package nsd_pkg;

    localparam int MAX_SPHERES_DEF = 64;
    localparam int SCALE_W         = 31;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd32768;

    // arithmetic widths
    localparam int SQ_W   = 66;   // sum of three squared 32-bit magnitudes
    localparam int DIST_W = 35;   // signed surface distance before saturation
    localparam int MAG_W  = 34;   // magnitude of that distance
    localparam int NUM_W  = 42;   // magnitude * 255

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic               req_type;
        logic               first_of_set;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        sphere_radius;
    } req_t;

    typedef struct packed {
        logic signed [31:0] signed_distance;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               no_spheres;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        r;
    } sphere_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAUNCH,
        ST_WAIT,
        ST_PREP,
        ST_DIV,
        ST_RESULT
    } nsd_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SQUARE,
        DS_ROOT,
        DS_DONE
    } dist_state_t;

endpackage

@@ sv/nsd_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_dist
// Signed surface distance of one vertex to one sphere: three squares through
// one 32x32 multiplier, then a bit-per-cycle integer square root.
// ----------------------------------------------------------------------------
module nsd_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  nsd_pkg::sphere_t                  sphere,
    input  logic signed [31:0]                vx,
    input  logic signed [31:0]                vy,
    input  logic signed [31:0]                vz,
    output logic                              done,
    output logic signed [nsd_pkg::DIST_W-1:0] surf_dist
);
    import nsd_pkg::*;

    dist_state_t       state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [31:0]       dx_reg, dx_next;
    logic [31:0]       dy_reg, dy_next;
    logic [31:0]       dz_reg, dz_next;
    logic [30:0]       rad_reg, rad_next;
    logic [63:0]       prod_reg, prod_next;
    logic [SQ_W-1:0]   acc_reg, acc_next;
    logic [SQ_W-1:0]   res_reg, res_next;
    logic [SQ_W-1:0]   one_reg, one_next;
    logic [31:0]       mul_op;
    logic [SQ_W-1:0]   trial;

    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] m;
        d = 33'(a) - 33'(b);
        m = d[32] ? -d : d;
        return m[31:0];
    endfunction

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        rad_reg  <= rad_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        one_reg  <= one_next;
    end

    // sequencer: square/accumulate, then root, then report
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        rad_next   = rad_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        one_next   = one_reg;
        done       = 1'b0;
        trial      = res_reg + one_reg;
        surf_dist  = DIST_W'({1'b0, res_reg[MAG_W-1:0]}) - DIST_W'(rad_reg);

        case (cnt_reg)
            2'd0:    mul_op = dx_reg;
            2'd1:    mul_op = dy_reg;
            default: mul_op = dz_reg;
        endcase

        case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    dx_next    = abs_diff(sphere.x, vx);
                    dy_next    = abs_diff(sphere.y, vy);
                    dz_next    = abs_diff(sphere.z, vz);
                    rad_next   = sphere.r;
                    acc_next   = '0;
                    cnt_next   = 2'd0;
                    state_next = DS_SQUARE;
                end
            end
            DS_SQUARE:
            begin
                if (cnt_reg != 2'd3)
                begin
                    prod_next = mul_op * mul_op;
                end
                if (cnt_reg != 2'd0)
                begin
                    acc_next = acc_reg + SQ_W'(prod_reg);
                end
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    res_next   = '0;
                    one_next   = SQ_W'(1) << (SQ_W - 2);
                    state_next = DS_ROOT;
                end
            end
            DS_ROOT:
            begin
                if (acc_reg >= trial)
                begin
                    acc_next = acc_reg - trial;
                    res_next = (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                one_next = one_reg >> 2;
                if (one_reg[0])
                begin
                    state_next = DS_DONE;
                end
            end
            DS_DONE:
            begin
                done       = 1'b1;
                state_next = DS_IDLE;
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

endmodule

@@ sv/nearest_sphere_distance_color.sv @@
`timescale 1ns / 1ps
// Load transfer: the sphere is written to the table at the edge that takes it, unless it is full.
// Query transfer: for each stored sphere, one memory read, then the squares and the
// square root; then the shade division. An empty table goes straight to the result.
// One item at a time; a finished result waits in the output register.
// Reset: table empty, scale 0.5 (Q16.16), no result pending; stores are not cleared.
// ----------------------------------------------------------------------------
// nearest_sphere_distance_color
// Sphere table in a synchronous memory, swept per query to find the surface
// of least absolute distance, with false-color shading of that distance.
// ----------------------------------------------------------------------------
module nearest_sphere_distance_color #(
    parameter int MAX_SPHERES = nsd_pkg::MAX_SPHERES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  nsd_pkg::req_t                req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output nsd_pkg::rsp_t                rsp_data,
    input  logic                         cfg_we,
    input  logic [nsd_pkg::SCALE_W-1:0]  cfg_wdata
);
    import nsd_pkg::*;

    localparam int CW = $clog2(MAX_SPHERES + 1);
    localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SPHERES);

    nsd_state_t               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [SCALE_W-1:0]       scale_reg;
    logic signed [31:0]       vx_reg, vx_next;
    logic signed [31:0]       vy_reg, vy_next;
    logic signed [31:0]       vz_reg, vz_next;
    logic signed [DIST_W-1:0] best_reg, best_next;
    logic [MAG_W-1:0]         bmag_reg, bmag_next;
    logic [NUM_W-1:0]         rem_reg, rem_next;
    logic [7:0]               quot_reg, quot_next;
    logic [2:0]               bit_reg, bit_next;
    logic                     empty_reg, empty_next;
    rsp_t                     rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    sphere_t                  mem [MAX_SPHERES];
    sphere_t                  rd_reg;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    sphere_t                  wr_data;

    logic                     dist_start;
    logic                     dist_done;
    logic signed [DIST_W-1:0] dist_val;
    logic [MAG_W-1:0]         dist_mag;
    logic [SCALE_W-1:0]       scale_use;
    logic [NUM_W-1:0]         div_trial;
    logic [NUM_W-1:0]         num;
    logic [CW-1:0]            base;
    logic [CW-1:0]            idx_inc;
    logic [7:0]               shade;
    logic                     in_xfer;

    // sphere table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    nsd_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dist_start),
        .sphere    (rd_reg),
        .vx        (vx_reg),
        .vy        (vy_reg),
        .vz        (vz_reg),
        .done      (dist_done),
        .surf_dist (dist_val)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scale_reg     <= SCALE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        vz_reg    <= vz_next;
        best_reg  <= best_next;
        bmag_reg  <= bmag_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        bit_reg   <= bit_next;
        empty_reg <= empty_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign in_xfer   = req_valid && !req_stall;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        best_next      = best_reg;
        bmag_next      = bmag_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        bit_next       = bit_reg;
        empty_next     = empty_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        dist_start     = 1'b0;

        base      = req_data.first_of_set ? '0 : count_reg;
        wr_addr   = base[AW-1:0];
        wr_data   = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z,
                      r: req_data.sphere_radius};
        idx_inc   = idx_reg + CW'(1);
        dist_mag  = dist_val[DIST_W-1] ? MAG_W'(-dist_val) : MAG_W'(dist_val);
        scale_use = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
        num       = {bmag_reg, 8'd0} - NUM_W'(bmag_reg);
        div_trial = NUM_W'(scale_use) << bit_reg;
        shade     = 8'd255 - quot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (req_data.req_type == REQ_LOAD)
                    begin
                        if (base < MAX_C)
                        begin
                            wr_en      = 1'b1;
                            count_next = base + CW'(1);
                        end
                        else
                        begin
                            count_next = base;
                        end
                    end
                    else
                    begin
                        vx_next    = req_data.pos_x;
                        vy_next    = req_data.pos_y;
                        vz_next    = req_data.pos_z;
                        idx_next   = '0;
                        empty_next = (count_reg == '0);
                        state_next = (count_reg == '0) ? ST_RESULT : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                dist_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (dist_done)
                begin
                    // strict compare keeps the first sphere on a tie
                    if (idx_reg == '0 || dist_mag < bmag_reg)
                    begin
                        best_next = dist_val;
                        bmag_next = dist_mag;
                    end
                    idx_next   = idx_inc;
                    state_next = (idx_inc == count_reg) ? ST_PREP : ST_READ;
                end
            end
            ST_PREP:
            begin
                rem_next  = num;
                quot_next = '0;
                bit_next  = 3'd7;
                if (num >= (NUM_W'(scale_use) << 8))
                begin
                    quot_next  = 8'd255;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (rem_reg >= div_trial)
                begin
                    rem_next            = rem_reg - div_trial;
                    quot_next[bit_reg]  = 1'b1;
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (empty_reg)
                    begin
                        rsp_next = '{signed_distance: 32'sd0, red: 8'd255,
                                     green: 8'd255, blue: 8'd255, no_spheres: 1'b1};
                    end
                    else
                    begin
                        if (best_reg > DIST_W'(32'sh7FFFFFFF))
                        begin
                            rsp_next.signed_distance = 32'sh7FFFFFFF;
                        end
                        else if (best_reg < -DIST_W'(33'sh080000000))
                        begin
                            rsp_next.signed_distance = 32'sh80000000;
                        end
                        else
                        begin
                            rsp_next.signed_distance = best_reg[31:0];
                        end
                        rsp_next.no_spheres = 1'b0;
                        if (best_reg[DIST_W-1])
                        begin
                            rsp_next.red   = shade;
                            rsp_next.green = shade;
                            rsp_next.blue  = 8'd255;
                        end
                        else
                        begin
                            rsp_next.red   = 8'd255;
                            rsp_next.green = shade;
                            rsp_next.blue  = shade;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("sphere count past capacity");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> state_reg == ST_WAIT)
        else $error("distance unit finished outside the sweep");

    a_empty_white: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.no_spheres |->
            rsp_data.signed_distance == 32'sd0 && rsp_data.red == 8'd255 &&
            rsp_data.green == 8'd255 && rsp_data.blue == 8'd255)
        else $error("empty-table result not white at zero distance");

    a_color_side: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.red == 8'd255 || rsp_data.blue == 8'd255)
        else $error("both red and blue reduced");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_sphere_distance_color: sphere loads and
// vertex queries go in over a valid/stall channel. A scoreboard class keeps
// its own copy of the sphere table and the color scale, predicts each query
// result and checks the results in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import nsd_pkg::*;

    localparam int  TABLE_DEPTH = 64;
    localparam int  CYCLE_LIMIT = 10000000;

    // ------------------------------------------------------------------------
    // Shade predictor and ordered store of expected query results
    // ------------------------------------------------------------------------
    class shade_scoreboard;
        logic [31:0] cx [TABLE_DEPTH];
        logic [31:0] cy [TABLE_DEPTH];
        logic [31:0] cz [TABLE_DEPTH];
        logic [30:0] rad [TABLE_DEPTH];
        int unsigned n_spheres;
        logic [30:0] scale;
        rsp_t        pending_q[$];
        int          fails;

        function new();
            n_spheres = 0;
            scale     = SCALE_RESET;
            fails     = 0;
        endfunction

        function longint unsigned axis_gap(logic [31:0] a, logic [31:0] b);
            longint d;
            d = longint'($signed(a)) - longint'($signed(b));
            return (d < 0) ? longint'(-d) : d;
        endfunction

        // floor of the square root; the root is below 2^34
        function longint unsigned int_root(logic [67:0] s);
            logic [71:0] r;
            logic [71:0] c;
            r = '0;
            for (int b = 35; b >= 0; b--)
            begin
                c = r | (72'd1 << b);
                if (c * c <= {4'd0, s})
                    r = c;
            end
            return r[63:0];
        endfunction

        function longint surface_dist(int i, req_t q);
            logic [67:0]     sum;
            longint unsigned dx, dy, dz;
            dx  = axis_gap(cx[i], q.pos_x);
            dy  = axis_gap(cy[i], q.pos_y);
            dz  = axis_gap(cz[i], q.pos_z);
            sum = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
            return longint'(int_root(sum)) - longint'({33'd0, rad[i]});
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // append one expected result at the tail
        function void add_expected(rsp_t e);
            pending_q = {pending_q, e};
        endfunction

        // note an accepted request; a query queues its expected result
        function void note(req_t q);
            rsp_t            e;
            longint          best, d, sat;
            longint unsigned mag, best_mag, sc, diff;
            if (q.req_type == REQ_LOAD)
            begin
                if (q.first_of_set)
                    n_spheres = 0;
                if (n_spheres < TABLE_DEPTH)
                begin
                    cx[n_spheres]  = q.pos_x;
                    cy[n_spheres]  = q.pos_y;
                    cz[n_spheres]  = q.pos_z;
                    rad[n_spheres] = q.sphere_radius;
                    n_spheres++;
                end
                return;
            end
            e = '0;
            if (n_spheres == 0)
            begin
                e.red        = 8'd255;
                e.green      = 8'd255;
                e.blue       = 8'd255;
                e.no_spheres = 1'b1;
                add_expected(e);
                return;
            end
            best     = surface_dist(0, q);
            best_mag = (best < 0) ? -best : best;
            for (int i = 1; i < n_spheres; i++)
            begin
                d   = surface_dist(i, q);
                mag = (d < 0) ? -d : d;
                // strict compare keeps the first sphere on a tie
                if (mag < best_mag)
                begin
                    best     = d;
                    best_mag = mag;
                end
            end
            sat = best;
            if (sat > 64'sd2147483647)
                sat = 64'sd2147483647;
            if (sat < -64'sd2147483648)
                sat = -64'sd2147483648;
            e.signed_distance = sat[31:0];
            sc   = (scale == 0) ? 1 : scale;
            diff = (best_mag * 255) / sc;
            if (diff > 255)
                diff = 255;
            if (best < 0)
            begin
                e.red   = 8'(255 - diff);
                e.green = 8'(255 - diff);
                e.blue  = 8'd255;
            end
            else
            begin
                e.red   = 8'd255;
                e.green = 8'(255 - diff);
                e.blue  = 8'(255 - diff);
            end
            add_expected(e);
        endfunction

        function void check(rsp_t got);
            rsp_t e;
            if (pending_q.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", got);
                fails++;
                return;
            end
            e = pending_q.pop_front();
            if (got.signed_distance !== e.signed_distance)
            begin
                $error("signed_distance exp %0d got %0d", e.signed_distance,
                       got.signed_distance);
                fails++;
            end
            if (got.red !== e.red)
            begin
                $error("red exp %0d got %0d", e.red, got.red);
                fails++;
            end
            if (got.green !== e.green)
            begin
                $error("green exp %0d got %0d", e.green, got.green);
                fails++;
            end
            if (got.blue !== e.blue)
            begin
                $error("blue exp %0d got %0d", e.blue, got.blue);
                fails++;
            end
            if (got.no_spheres !== e.no_spheres)
            begin
                $error("no_spheres exp %0d got %0d", e.no_spheres, got.no_spheres);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_data;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_data;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    shade_scoreboard sb;
    int  n_sent;
    int  cycles;
    bit  no_idle;
    logic [31:0] base_x, base_y, base_z;

    nearest_sphere_distance_color u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check(rsp_data);
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result stall pattern
    initial
    begin
        int run;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            run = gap_len();
            if (run > 0)
            begin
                rsp_stall = 1'b1;
                repeat (run) @(negedge clk);
                rsp_stall = 1'b0;
            end
        end
    end

    // one request transfer, with a random gap before it
    task automatic send(req_t q);
        int g;
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            req_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = q;
        do
            @(posedge clk);
        while (req_stall);
        sb.note(q);
        n_sent++;
    endtask

    task automatic load(logic first, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [30:0] r);
        req_t q;
        q = '{req_type: REQ_LOAD, first_of_set: first, pos_x: x, pos_y: y,
              pos_z: z, sphere_radius: r};
        send(q);
    endtask

    task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        req_t q;
        q = '{req_type: REQ_QUERY, first_of_set: 1'($urandom), pos_x: x, pos_y: y,
              pos_z: z, sphere_radius: 31'($urandom)};
        send(q);
    endtask

    // hold off until every expected result is back and the block is idle
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_scale(logic [30:0] v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.scale  = v;
    endtask

    function automatic logic [31:0] near_base(logic [31:0] b);
        return b + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    // stimulus
    initial
    begin
        int n_load, n_query;
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cycles    = 0;
        n_sent    = 0;
        no_idle   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, saturation, tie, surface, inside
        query(32'h0, 32'h0, 32'h0);
        query(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        load(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load(1'b1, 32'd10, 32'd0, 32'd0, 31'd5);
        load(1'b0, -32'sd3, 32'd0, 32'd0, 31'd8);
        query(32'd0, 32'd0, 32'd0);
        load(1'b1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 31'h7FFF_FFFF);
        query(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
        load(1'b1, 32'h0000_4000, 32'h0, 32'h0, 31'h0001_0000);
        query(32'h0001_4000, 32'h0, 32'h0);
        query(32'h0000_8000, 32'h0, 32'h0);
        query(32'h0001_0000, 32'h0, 32'h0);
        write_scale(31'd1);
        query(32'h0001_4001, 32'h0, 32'h0);
        query(32'h0000_4000, 32'h0, 32'h0);
        write_scale(31'h7FFF_FFFF);
        query(32'h7FFF_0000, 32'h0, 32'h0);
        query(32'h0000_4000, 32'h0, 32'h0);
        write_scale(31'd0);
        query(32'h0000_4000, 32'h0000_0003, 32'h0);

        // table capacity: loads past the last entry are dropped
        write_scale(31'h0004_0000);
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            load(i == 0, 32'(i) << 16, 32'($urandom), 32'h0, 31'($urandom_range(0, 1 << 18)));
        query(32'h0042_0000, 32'h0, 32'h0);
        query(32'($urandom), 32'($urandom), 32'($urandom));

        // random phases: well-formed sets around a random center, then noise
        while (n_sent < 650)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_scale(31'd1);
                    1: write_scale(31'h7FFF_FFFF);
                    2: write_scale(SCALE_RESET);
                    default: write_scale(31'($urandom_range(1 << 10, 1 << 22)));
                endcase
            end
            else if ($urandom_range(0, 9) == 0)
                drain();
            no_idle = ($urandom_range(0, 4) == 0);
            base_x  = $urandom;
            base_y  = $urandom;
            base_z  = $urandom;
            n_load  = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 8);
            n_query = $urandom_range(1, 6);
            for (int i = 0; i < n_load; i++)
                load(i == 0, near_base(base_x), near_base(base_y), near_base(base_z),
                     31'($urandom_range(0, 1 << 20)));
            for (int i = 0; i < n_query; i++)
                query(near_base(base_x), near_base(base_y), near_base(base_z));
            // noise: arbitrary loads that add to the set, and arbitrary queries
            repeat ($urandom_range(0, 2))
            begin
                if ($urandom_range(0, 1))
                    load(1'b0, $urandom, $urandom, $urandom, 31'($urandom));
                else
                    query($urandom, $urandom, $urandom);
            end
        end

        // drain and finish
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
